// ----- hdl/cpfa_pkg.sv -----
`timescale 1ns / 1ps

package cpfa_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CENTRE_X = 2'd0;
    localparam logic [1:0] REG_CENTRE_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    // Field widths
    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;

    // Fixed-point layout
    localparam int COORD_FRAC_BITS = 16;
    localparam int GUARD_BITS      = 8;
    localparam int ANGLE_SHIFT     = 17;   // Q3.13 angle -> 2^-30 rad residue

    // Rotation depth, bounded by the arctangent table
    localparam int ROTATION_STAGES = 16;
    localparam int TABLE_LEN       = 24;
    localparam int CORDIC_STAGES   = (ROTATION_STAGES < TABLE_LEN) ?
                                     ROTATION_STAGES : TABLE_LEN;

    // Gain compensation K in Q30, and its product with the radius
    localparam int K_W    = 30;
    localparam int PROD_W = RADIUS_W + K_W;
    localparam logic [K_W-1:0] GAIN_K_Q30 = 30'd652032874;
    localparam int START_SHIFT = 30 - GUARD_BITS;

    // Datapath widths: vector carries guard bits plus headroom for gain
    localparam int XY_W  = RADIUS_W + GUARD_BITS + 3;
    localparam int Z_W   = ANGLE_W + ANGLE_SHIFT + 1;
    localparam int RND_W = XY_W - GUARD_BITS;
    localparam int SUM_W = RND_W + 1;

    localparam logic signed [Z_W-1:0] PI_Z      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Z = 34'sd1686629713;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << COORD_FRAC_BITS;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // atan(2^-i) in units of 2^-30 rad
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314857;
            1:       v = 30'd497837829;
            2:       v = 30'd263043837;
            3:       v = 30'd133525159;
            4:       v = 30'd67021687;
            5:       v = 30'd33543516;
            6:       v = 30'd16775851;
            7:       v = 30'd8388437;
            8:       v = 30'd4194283;
            9:       v = 30'd2097149;
            10:      v = 30'd1048576;
            11:      v = 30'd524288;
            12:      v = 30'd262144;
            13:      v = 30'd131072;
            14:      v = 30'd65536;
            15:      v = 30'd32768;
            16:      v = 30'd16384;
            17:      v = 30'd8192;
            18:      v = 30'd4096;
            19:      v = 30'd2048;
            20:      v = 30'd1024;
            21:      v = 30'd512;
            22:      v = 30'd256;
            23:      v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/circle_point_from_angle_core.sv -----
`timescale 1ns / 1ps
// Pipeline: the word passes CORDIC_STAGES + 3 registers, the first loaded on the accepting
//   edge: radius*K multiply and quadrant fold, one per CORDIC stage, rounding, centre add.
// Throughput: one word per cycle; the whole pipeline holds while m_valid waits on m_ready.
// Reset (aresetn low, synchronous): pipeline emptied, centre = 0, radius = 1.0.
module circle_point_from_angle_core
    import cpfa_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [COORD_W-1:0]         cfg_wdata,
    // angle input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [ANGLE_W-1:0]  s_angle,
    // point output
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COORD_W-1:0]  m_point_x,
    output logic signed [COORD_W-1:0]  m_point_y
);

    // Configuration registers
    logic signed [COORD_W-1:0]  centre_x_reg;
    logic signed [COORD_W-1:0]  centre_y_reg;
    logic [RADIUS_W-1:0]        radius_reg;

    // Front stage: multiply and fold
    logic                       v0_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic signed [Z_W-1:0]      z0_reg;
    logic [PROD_W-1:0]          prod_next;
    logic                       neg_next;
    logic signed [Z_W-1:0]      z0_next;
    logic signed [Z_W-1:0]      z_start;

    // CORDIC stages
    logic                       vld_reg  [CORDIC_STAGES];
    logic signed [XY_W-1:0]     x_reg    [CORDIC_STAGES];
    logic signed [XY_W-1:0]     y_reg    [CORDIC_STAGES];
    logic signed [Z_W-1:0]      z_reg    [CORDIC_STAGES];
    logic signed [XY_W-1:0]     x_next   [CORDIC_STAGES];
    logic signed [XY_W-1:0]     y_next   [CORDIC_STAGES];
    logic signed [Z_W-1:0]      z_next   [CORDIC_STAGES];
    logic signed [XY_W-1:0]     x_start;

    // Rounding stage
    logic                       vr_reg;
    logic signed [RND_W-1:0]    xr_reg;
    logic signed [RND_W-1:0]    yr_reg;
    logic signed [XY_W-1:0]     xr_sum;
    logic signed [XY_W-1:0]     yr_sum;
    logic signed [RND_W-1:0]    xr_next;
    logic signed [RND_W-1:0]    yr_next;

    // Output stage
    logic                       m_valid_reg;
    logic signed [COORD_W-1:0]  m_point_x_reg;
    logic signed [COORD_W-1:0]  m_point_y_reg;
    logic signed [SUM_W-1:0]    sx;
    logic signed [SUM_W-1:0]    sy;
    logic signed [COORD_W-1:0]  m_point_x_next;
    logic signed [COORD_W-1:0]  m_point_y_next;

    logic                       advance;

    // Whole pipeline moves unless the output word is stalled
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // Configuration writes; unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTRE_X: centre_x_reg <= cfg_wdata;
                REG_CENTRE_Y: centre_y_reg <= cfg_wdata;
                REG_RADIUS:   radius_reg   <= cfg_wdata[RADIUS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Front: scale radius by K, fold angle into -pi/2..pi/2
    always_comb begin
        prod_next = PROD_W'(radius_reg) * PROD_W'(GAIN_K_Q30);
        z_start   = Z_W'(s_angle) <<< ANGLE_SHIFT;
        neg_next  = 1'b0;
        z0_next   = z_start;
        if (z_start > HALF_PI_Z) begin
            z0_next  = z_start - PI_Z;
            neg_next = 1'b1;
        end else if (z_start < -HALF_PI_Z) begin
            z0_next  = z_start + PI_Z;
            neg_next = 1'b1;
        end
    end

    // Starting vector: radius*K with guard bits, negated for the far half
    always_comb begin
        x_start = XY_W'(prod_reg[PROD_W-1:START_SHIFT]);
        if (neg_reg) begin
            x_start = -x_start;
        end
    end

    // One micro-rotation per stage, shift amount fixed per stage
    always_comb begin
        logic signed [XY_W-1:0] xi;
        logic signed [XY_W-1:0] yi;
        logic signed [Z_W-1:0]  zi;
        logic signed [Z_W-1:0]  at;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                xi = x_start;
                yi = '0;
                zi = z0_reg;
            end else begin
                xi = x_reg[i-1];
                yi = y_reg[i-1];
                zi = z_reg[i-1];
            end
            at = Z_W'(atan_q30(i));
            if (!zi[Z_W-1]) begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - at;
            end else begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + at;
            end
        end
    end

    // Round half up, drop guard bits
    always_comb begin
        xr_sum  = x_reg[CORDIC_STAGES-1] + XY_W'(1 << (GUARD_BITS - 1));
        yr_sum  = y_reg[CORDIC_STAGES-1] + XY_W'(1 << (GUARD_BITS - 1));
        xr_next = xr_sum[XY_W-1:GUARD_BITS];
        yr_next = yr_sum[XY_W-1:GUARD_BITS];
    end

    // Add centre and saturate to the coordinate range
    always_comb begin
        sx = SUM_W'(centre_x_reg) + SUM_W'(xr_reg);
        sy = SUM_W'(centre_y_reg) + SUM_W'(yr_reg);
        if (sx > SUM_W'(COORD_MAX)) begin
            m_point_x_next = COORD_MAX;
        end else if (sx < SUM_W'(COORD_MIN)) begin
            m_point_x_next = COORD_MIN;
        end else begin
            m_point_x_next = sx[COORD_W-1:0];
        end
        if (sy > SUM_W'(COORD_MAX)) begin
            m_point_y_next = COORD_MAX;
        end else if (sy < SUM_W'(COORD_MIN)) begin
            m_point_y_next = COORD_MIN;
        end else begin
            m_point_y_next = sy[COORD_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            vr_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            v0_reg      <= s_valid;
            vld_reg[0]  <= v0_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            vr_reg      <= vld_reg[CORDIC_STAGES-1];
            m_valid_reg <= vr_reg;
        end
    end

    // Data registers
    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
            z0_reg   <= z0_next;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            xr_reg        <= xr_next;
            yr_reg        <= yr_next;
            m_point_x_reg <= m_point_x_next;
            m_point_y_reg <= m_point_y_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_point_x = m_point_x_reg;
    assign m_point_y = m_point_y_reg;

`ifndef SYNTHESIS
    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // An accepted word enters the front stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v0_reg)
        else $error("accepted word lost at front stage");

    // A stall freezes the front, first rotation, last rotation and rounding valid bits
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(v0_reg) && $stable(vld_reg[0]) &&
                     $stable(vld_reg[CORDIC_STAGES-1]) && $stable(vr_reg))
        else $error("pipeline moved during stall");

    // Last rotation stage feeds the rounding stage
    a_round_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && vld_reg[CORDIC_STAGES-1] |=> vr_reg)
        else $error("word dropped between rotation and rounding");
`endif

endmodule
